// ----- rtl/solarize_pixel_filter_assert.svh -----
// Assertion helpers for the solarize filter RTL.
// All checks sample on clk and are off while rst_n is low.
`ifndef SOLARIZE_PIXEL_FILTER_ASSERT_SVH
`define SOLARIZE_PIXEL_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SOL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/sol_pkg.sv -----
package sol_pkg;

  localparam int CHAN_W    = 8;
  localparam int THR_W     = 9;   // threshold 1..256
  localparam int INT_W     = 10;  // intensity register width
  localparam int NUM_W     = 16;  // channel * 255
  localparam int RECIP_SH  = 24;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int RECIP_N   = 256; // divisors 1..256
  localparam int IDX_W     = 8;
  localparam int THR_MUL_W = 17;
  localparam int THR_SH    = 17;
  localparam int REG_IDX_W = 1;

  localparam logic [CHAN_W-1:0]    CHAN_MAX    = 8'hff;
  localparam logic [INT_W-1:0]     INT_FULL    = 10'd1000;
  // floor(x * 256 / 1000) == (x * 33555) >> 17 for x up to 1000
  localparam logic [THR_MUL_W-1:0] THR_MUL     = 17'd33555;
  localparam logic [THR_W-1:0]     THR_RST     = 9'd256;
  localparam logic [THR_W-1:0]     THR_MIN     = 9'd1;

  localparam logic [REG_IDX_W-1:0] REG_INTENSITY = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_STRETCH   = 1'd1;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic             stretch;
  } sol_cfg_t;

endpackage

// ----- rtl/solarize_pixel_filter.sv -----
// Path: an accepted item moves through the s1 register, then the output register that drives out_tvalid.
// Throughput: 1 item per cycle unless out_tready stalls the output; each colour lane has one table
// lookup stage and one reciprocal multiply stage, so nothing iterates.
// Reset (rst_n low, synchronous): pipeline emptied, intensity threshold 256,
// stretch mode on. Ready for items in the first cycle after reset.
`include "solarize_pixel_filter_assert.svh"

module solarize_pixel_filter
  import sol_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // alpha_in, red_in, green_in, blue_in
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // alpha_out, red_out, green_out, blue_out
  output logic                 out_tlast,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [INT_W-1:0]     cfg_wdata
);

  localparam int NLANES = 3;

  sol_cfg_t          cfg;
  logic              s1_v_r, s1_v_nxt;
  logic              out_v_r, out_v_nxt;
  logic              s2_ready, accept, advance;
  logic [CHAN_W-1:0] alpha1_r, alpha2_r;
  logic              last1_r, last2_r;
  logic [CHAN_W-1:0] lane_out [NLANES];

  sol_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // lane 0 red, 1 green, 2 blue
  for (genvar i = 0; i < NLANES; i++) begin : g_lane
    sol_lane u_lane (
      .clk      (clk),
      .cfg      (cfg),
      .ld_s1    (accept),
      .ld_s2    (advance),
      .chan_in  (in_tdata[(i+1)*CHAN_W +: CHAN_W]),
      .chan_out (lane_out[i])
    );
  end

  always_comb begin
    s2_ready  = !out_v_r || out_tready;
    in_tready = !s1_v_r || s2_ready;
    accept    = in_tvalid && in_tready;
    advance   = s1_v_r && s2_ready;
    s1_v_nxt  = accept ? 1'b1 : (advance ? 1'b0 : s1_v_r);
    out_v_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alpha1_r <= in_tdata[CHAN_W-1:0];
      last1_r  <= in_tlast;
    end
    if (advance) begin
      alpha2_r <= alpha1_r;
      last2_r  <= last1_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {lane_out[2], lane_out[1], lane_out[0], alpha2_r};
  assign out_tlast  = last2_r;

  `SOL_ASSERT_NOW(a_thr_range, 1'b1, (cfg.thr != '0) && (cfg.thr <= THR_RST))
  `SOL_ASSERT_NOW(a_stall_only_full, !in_tready, s1_v_r && out_tvalid && !out_tready)
  `SOL_ASSERT_NEXT(a_accept_fills_s1, accept, s1_v_r)
  `SOL_ASSERT_NEXT(a_s1_to_out, s1_v_r && !out_tvalid, out_tvalid)

endmodule

// ----- rtl/sol_cfg.sv -----
module sol_cfg
  import sol_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [INT_W-1:0]     cfg_wdata,
  output sol_cfg_t             cfg
);

  logic [THR_W-1:0]           thr_r, thr_nxt;
  logic                       stretch_r, stretch_nxt;
  logic [INT_W-1:0]           span;
  logic [INT_W+THR_MUL_W-1:0] prod;
  logic [THR_W-1:0]           thr_raw;

  // threshold is resolved once at write time, stored directly
  always_comb begin
    span    = (cfg_wdata > INT_FULL) ? '0 : INT_FULL - cfg_wdata;
    prod    = (INT_W+THR_MUL_W)'(span) * (INT_W+THR_MUL_W)'(THR_MUL);
    thr_raw = prod[THR_SH +: THR_W];
    thr_nxt = thr_r;
    stretch_nxt = stretch_r;
    if (cfg_wen) begin
      case (cfg_addr)
        REG_INTENSITY: thr_nxt = (thr_raw == '0) ? THR_MIN : thr_raw;
        REG_STRETCH:   stretch_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RST;
      stretch_r <= 1'b1;
    end else begin
      thr_r     <= thr_nxt;
      stretch_r <= stretch_nxt;
    end
  end

  assign cfg.thr     = thr_r;
  assign cfg.stretch = stretch_r;

endmodule

// ----- rtl/sol_lane.sv -----
module sol_lane
  import sol_pkg::*;
(
  input  logic              clk,
  input  sol_cfg_t          cfg,
  input  logic              ld_s1,
  input  logic              ld_s2,
  input  logic [CHAN_W-1:0] chan_in,
  output logic [CHAN_W-1:0] chan_out
);

  logic [RECIP_W-1:0] recip_tbl [RECIP_N];

  // ceil(2^24 / d): exact floor quotient for numerators up to 255*255
  for (genvar g = 0; g < RECIP_N; g++) begin : g_recip
    localparam int RecipInt = ((1 << RECIP_SH) + g) / (g + 1);
    assign recip_tbl[g] = RECIP_W'(RecipInt);
  end

  logic                     above;
  logic [CHAN_W-1:0]        inv, src;
  logic [NUM_W-1:0]         num;
  logic [THR_W-1:0]         dvs;
  logic [THR_W-1:0]         dvs_m1;
  logic [NUM_W-1:0]         num_r;
  logic [RECIP_W-1:0]       recip_r;
  logic [CHAN_W-1:0]        plain_r;
  logic                     stretch_r;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [CHAN_W-1:0]        quot;
  logic [CHAN_W-1:0]        out_r;

  always_comb begin
    above  = {1'b0, chan_in} > cfg.thr;
    inv    = CHAN_MAX - chan_in;
    src    = above ? inv : chan_in;
    num    = {src, {CHAN_W{1'b0}}} - NUM_W'(src);
    // above threshold implies thr <= 254, so 255 - thr fits 8 bits and is nonzero
    dvs    = above ? {1'b0, CHAN_MAX - cfg.thr[CHAN_W-1:0]} : cfg.thr;
    dvs_m1 = dvs - THR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ld_s1) begin
      num_r     <= num;
      recip_r   <= recip_tbl[dvs_m1[IDX_W-1:0]];
      plain_r   <= src;
      stretch_r <= cfg.stretch;
    end
  end

  always_comb begin
    prod = (NUM_W+RECIP_W)'(num_r) * (NUM_W+RECIP_W)'(recip_r);
    quot = prod[RECIP_SH +: CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (ld_s2) begin
      out_r <= stretch_r ? quot : plain_r;
    end
  end

  assign chan_out = out_r;

endmodule

// ----- tb/sv/solarize_pixel_filter_test.sv -----
module solarize_pixel_filter_test;
  import sol_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } pixel_t;

  typedef struct packed {
    logic [INT_W-1:0] tenths;
    logic             stretch;
    pixel_t           pix;
    logic             known;    // want is typed in, otherwise predicted
    pixel_t           want;
  } dir_row_t;

  localparam int unsigned FULL_TENTHS = 1000;
  localparam int unsigned LEVELS      = 256;
  localparam int unsigned TOP         = 255;
  localparam int          NUM_BLOCKS  = 12;
  localparam int          BLOCK_ITEMS = 104;
  localparam int          HOLD_CYCLES = 90;
  localparam int          DRAIN_WAIT  = 6;

  localparam pixel_t NO_PIX = '0;
  localparam int     DIR_N  = 20;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // reset setting: threshold 256, stretch
    '{10'd0,    1'b1, '{8'h00, 8'h00, 8'hff, 8'h80, 1'b0}, 1'b1,
      '{8'h00, 8'h00, 8'hfe, 8'h7f, 1'b0}},
    '{10'd0,    1'b1, '{8'hff, 8'hff, 8'h01, 8'hfe, 1'b1}, 1'b0, NO_PIX},
    '{10'd0,    1'b1, '{8'h55, 8'haa, 8'h55, 8'h0f, 1'b0}, 1'b0, NO_PIX},
    // threshold 255 maps every channel onto itself
    '{10'd1,    1'b1, '{8'ha5, 8'hff, 8'hfe, 8'h00, 1'b0}, 1'b1,
      '{8'ha5, 8'hff, 8'hfe, 8'h00, 1'b0}},
    '{10'd7,    1'b1, '{8'h00, 8'hff, 8'hfe, 8'hfd, 1'b1}, 1'b0, NO_PIX},
    '{10'd500,  1'b1, '{8'h12, 8'h80, 8'h81, 8'h7f, 1'b0}, 1'b0, NO_PIX},
    '{10'd500,  1'b1, '{8'hff, 8'h00, 8'hff, 8'h01, 1'b0}, 1'b0, NO_PIX},
    // full intensity: threshold 1
    '{10'd1000, 1'b1, '{8'h00, 8'h00, 8'h01, 8'hff, 1'b1}, 1'b1,
      '{8'h00, 8'h00, 8'hff, 8'h00, 1'b1}},
    '{10'd1000, 1'b1, '{8'hff, 8'h02, 8'h80, 8'hfe, 1'b0}, 1'b0, NO_PIX},
    // intensity past full saturates
    '{10'd1001, 1'b1, '{8'h3c, 8'h00, 8'h01, 8'hff, 1'b0}, 1'b1,
      '{8'h3c, 8'h00, 8'hff, 8'h00, 1'b0}},
    '{10'd1023, 1'b1, '{8'hc3, 8'hff, 8'h01, 8'h00, 1'b1}, 1'b1,
      '{8'hc3, 8'h00, 8'hff, 8'h00, 1'b1}},
    '{10'd996,  1'b1, '{8'h00, 8'h01, 8'h02, 8'hff, 1'b0}, 1'b0, NO_PIX},
    // plain mode
    '{10'd0,    1'b0, '{8'h12, 8'h34, 8'h56, 8'h78, 1'b0}, 1'b1,
      '{8'h12, 8'h34, 8'h56, 8'h78, 1'b0}},
    '{10'd0,    1'b0, '{8'hff, 8'hff, 8'h00, 8'h80, 1'b1}, 1'b1,
      '{8'hff, 8'hff, 8'h00, 8'h80, 1'b1}},
    '{10'd1000, 1'b0, '{8'h00, 8'h00, 8'h01, 8'h02, 1'b0}, 1'b1,
      '{8'h00, 8'h00, 8'h01, 8'hfd, 1'b0}},
    '{10'd1023, 1'b0, '{8'hff, 8'hff, 8'h80, 8'h7f, 1'b1}, 1'b1,
      '{8'hff, 8'h00, 8'h7f, 8'h80, 1'b1}},
    '{10'd500,  1'b0, '{8'h5a, 8'h80, 8'h81, 8'hff, 1'b0}, 1'b1,
      '{8'h5a, 8'h80, 8'h7e, 8'h00, 1'b0}},
    '{10'd7,    1'b0, '{8'h00, 8'hfe, 8'hff, 8'hfd, 1'b0}, 1'b1,
      '{8'h00, 8'hfe, 8'h00, 8'hfd, 1'b0}},
    '{10'd7,    1'b1, '{8'h00, 8'hfe, 8'hff, 8'hfd, 1'b1}, 1'b0, NO_PIX},
    '{10'd0,    1'b1, '{8'h00, 8'h01, 8'hfe, 8'h7f, 1'b0}, 1'b0, NO_PIX}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;   // alpha, red, green, blue
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;         // alpha, red, green, blue
  logic                 out_tlast;
  logic                 cfg_wen    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr   = REG_INTENSITY;
  logic [INT_W-1:0]     cfg_wdata  = '0;

  logic [INT_W-1:0] cur_tenths  = '0;
  logic             cur_stretch = 1'b1;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  bit               rx_hold = 1'b0;

  pixel_t solarized_due [$];
  int     mismatches     = 0;
  int     directed_sent  = 0;
  int     random_sent    = 0;
  int     results_seen   = 0;
  int     reg_writes     = 0;

  solarize_pixel_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned solar_threshold(logic [INT_W-1:0] tenths);
    int unsigned x, t;
    x = (tenths > FULL_TENTHS) ? FULL_TENTHS : 32'(tenths);
    t = ((FULL_TENTHS - x) * LEVELS) / FULL_TENTHS;
    return (t < 1) ? 1 : t;
  endfunction

  function automatic logic [CHAN_W-1:0] solar_channel(logic [CHAN_W-1:0] c,
                                                      int unsigned t, logic stretch);
    int unsigned ci, r;
    ci = 32'(c);
    if (stretch) begin
      r = (ci > t) ? ((TOP - ci) * TOP) / (TOP - t) : (ci * TOP) / t;
    end else begin
      r = (ci > t) ? TOP - ci : ci;
    end
    return r[CHAN_W-1:0];
  endfunction

  function automatic pixel_t solarize_pixel(pixel_t p);
    int unsigned t;
    pixel_t q;
    t       = solar_threshold(cur_tenths);
    q       = p;
    q.red   = solar_channel(p.red, t, cur_stretch);
    q.green = solar_channel(p.green, t, cur_stretch);
    q.blue  = solar_channel(p.blue, t, cur_stretch);
    return q;
  endfunction

  // a channel value either fully random or within two of the threshold
  function automatic logic [CHAN_W-1:0] pick_channel(int unsigned t);
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = int'(t) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > int'(TOP)) v = int'(TOP);
      return v[CHAN_W-1:0];
    end
    return CHAN_W'($urandom_range(0, TOP));
  endfunction

  function automatic pixel_t random_pixel();
    int unsigned t;
    pixel_t p;
    t       = solar_threshold(cur_tenths);
    p.alpha = CHAN_W'($urandom_range(0, TOP));
    p.red   = pick_channel(t);
    p.green = pick_channel(t);
    p.blue  = pick_channel(t);
    p.last  = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(pixel_t p, pixel_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {p.blue, p.green, p.red, p.alpha};
    in_tlast  = p.last;
    do @(posedge clk); while (!in_tready);
    solarized_due.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (solarized_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [INT_W-1:0] data);
    cfg_wen   = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wen = 1'b0;
    if (idx == REG_INTENSITY) cur_tenths = data;
    else cur_stretch = data[0];
    reg_writes++;
  endtask

  task automatic set_mode(logic [INT_W-1:0] tenths, logic stretch);
    logic [INT_W-1:0] w;
    drain();
    write_reg(REG_INTENSITY, tenths);
    // upper bits of the mode write carry junk
    w    = INT_W'($urandom);
    w[0] = stretch;
    write_reg(REG_STRETCH, w);
  endtask

  task automatic send_block(int n);
    pixel_t p;
    repeat (n) begin
      p = random_pixel();
      send_pixel(p, solarize_pixel(p));
      random_sent++;
    end
  endtask

  task automatic hold_receiver();
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready = !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (solarized_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h last %b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = solarized_due.pop_front();
        check_field("alpha", 32'(want.alpha), 32'(out_tdata[7:0]));
        check_field("red",   32'(want.red),   32'(out_tdata[15:8]));
        check_field("green", 32'(want.green), 32'(out_tdata[23:16]));
        check_field("blue",  32'(want.blue),  32'(out_tdata[31:24]));
        check_field("last",  32'(want.last),  32'(out_tlast));
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t row;
    logic [INT_W-1:0] tenths;
    logic stretch;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      if (row.tenths != cur_tenths || row.stretch != cur_stretch)
        set_mode(row.tenths, row.stretch);
      send_pixel(row.pix, row.known ? row.want : solarize_pixel(row.pix));
      directed_sent++;
    end

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      case (blk)
        0:       tenths = '0;
        1:       tenths = INT_FULL;
        2:       tenths = '1;
        3:       tenths = 10'd7;
        default: tenths = INT_W'($urandom_range(0, 1023));
      endcase
      stretch = (blk < 4) ? blk[0] : 1'($urandom_range(0, 1));
      set_mode(tenths, stretch);
      if (blk < 4) begin
        send_idle_pct = 22;
        recv_idle_pct = 76;
      end else if (blk < 8) begin
        send_idle_pct = 76;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (blk == 5 || blk == 9) begin
        fork
          hold_receiver();
          send_block(BLOCK_ITEMS);
        join
      end else begin
        send_block(BLOCK_ITEMS);
      end
    end

    drain();
    $display("Covered %0d directed and %0d random pixels over %0d register writes,",
             directed_sent, random_sent, reg_writes);
    $display("%0d results checked, with both sides stalling and a long output hold.",
             results_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
